>>> sv/set_assoc_cache_tag_round_robin_top_macros.svh
// Assertion helpers used by sactr_ctrl; clocked on clk, quiet while rst_n is low.
`ifndef SET_ASSOC_CACHE_TAG_ROUND_ROBIN_TOP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_ROUND_ROBIN_TOP_MACROS_SVH

// same-cycle implication
`define SACTR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SACTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sactr_pkg.sv
`timescale 1ns / 1ps

package sactr_pkg;

    localparam int CFG_W = 4;
    localparam int IDX_W = 2;
    localparam int CNT_W = 32;
    localparam int ADR_W = 32;

    typedef enum logic [IDX_W-1:0] {
        REG_BLOCK_SHIFT = 2'd0,
        REG_SET_BITS    = 2'd1,
        REG_WAYS_IN_USE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [3:0] block_shift;
        logic [3:0] set_bits;
        logic [2:0] ways_in_use;
    } cfg_t;

    typedef struct packed {
        logic       fire;
        logic       hit;
        logic [1:0] way;
    } res_t;

endpackage

>>> sv/sactr_ram.sv
`timescale 1ns / 1ps

module sactr_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sactr_ctrl.sv
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_round_robin_top_macros.svh"

module sactr_ctrl #(
    parameter int SETS = 256,
    parameter int WAYS = 4,
    parameter int ADDR_BITS = 32,
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sactr_pkg::ADR_W-1:0]       address,
    input  sactr_pkg::cfg_t                   cfg,
    output logic                              busy,
    output sactr_pkg::res_t                   res,
    // tag memory, one row per set
    output logic                              tag_re,
    output logic [SET_W-1:0]                  tag_rd_addr,
    input  logic [WAYS-1:0][TAG_W-1:0]        tag_rd_data,
    output logic                              tag_we,
    output logic [SET_W-1:0]                  tag_wr_addr,
    output logic [WAYS-1:0][TAG_W-1:0]        tag_wr_data,
    // state memory: {valid per way, victim pointer}
    output logic                              st_re,
    output logic [SET_W-1:0]                  st_rd_addr,
    input  logic [WAYS+WAY_W-1:0]             st_rd_data,
    output logic                              st_we,
    output logic [SET_W-1:0]                  st_wr_addr,
    output logic [WAYS+WAY_W-1:0]             st_wr_data
);

    import sactr_pkg::*;

    localparam int LOG_SETS = $clog2(SETS);
    localparam int CW = 8;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
    localparam logic [31:0] AMASK = (TAG_W >= 32) ? 32'hFFFF_FFFF
                                    : 32'((64'd1 << TAG_W) - 64'd1);

    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SET_W-1:0] set_reg, set_next;
    logic [TAG_W-1:0] tag_reg, tag_next;

    logic             accept;
    logic [31:0]      blk;
    logic [31:0]      set_full;
    logic [31:0]      tag_full;
    logic [3:0]       sb_eff;
    logic [2:0]       nw_eff;

    logic [WAYS-1:0]  valid_q;
    logic [WAY_W-1:0] ptr_q;
    logic [WAYS-1:0]  match;
    logic             hit_any;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] v_sel;
    logic [CW-1:0]    v_inc;
    logic [WAY_W-1:0] ptr_new;
    logic [WAYS-1:0]  valid_new;
    logic [WAYS-1:0][TAG_W-1:0] tag_row_new;
    logic             miss_wb;

    assign accept = start && (state_reg == ST_IDLE);

    // address split: drop offset, low bits pick the set, the rest is the tag
    always_comb
    begin
        if (32'(cfg.set_bits) > LOG_SETS)
        begin
            sb_eff = 4'(LOG_SETS);
        end
        else
        begin
            sb_eff = cfg.set_bits;
        end
        blk      = (address & AMASK) >> cfg.block_shift;
        set_full = blk & ~(32'hFFFF_FFFF << sb_eff);
        tag_full = blk >> sb_eff;
        set_next = accept ? set_full[SET_W-1:0] : set_reg;
        tag_next = accept ? tag_full[TAG_W-1:0] : tag_reg;
    end

    always_comb
    begin
        if (cfg.ways_in_use == 3'd0)
        begin
            nw_eff = 3'd1;
        end
        else if (32'(cfg.ways_in_use) > WAYS)
        begin
            nw_eff = 3'(WAYS);
        end
        else
        begin
            nw_eff = cfg.ways_in_use;
        end
    end

    // compare against the row read for this set
    always_comb
    begin
        valid_q = st_rd_data[WAYS+WAY_W-1:WAY_W];
        ptr_q   = st_rd_data[WAY_W-1:0];
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = valid_q[w] && (tag_rd_data[w] == tag_reg) && (w < int'(nw_eff));
        end
        hit_any = |match;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
    end

    // round-robin victim; a stale pointer past the ways in use restarts at way 0
    always_comb
    begin
        if (CW'(ptr_q) >= CW'(nw_eff))
        begin
            v_sel = '0;
        end
        else
        begin
            v_sel = ptr_q;
        end
        v_inc = CW'(v_sel) + CW'(1);
        if (v_inc >= CW'(nw_eff))
        begin
            ptr_new = '0;
        end
        else
        begin
            ptr_new = WAY_W'(v_inc);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            valid_new[w]   = valid_q[w] | (v_sel == WAY_W'(w));
            tag_row_new[w] = (v_sel == WAY_W'(w)) ? tag_reg : tag_rd_data[w];
        end
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        miss_wb     = (state_reg == ST_LOOKUP) && !hit_any;
        tag_re      = accept;
        tag_rd_addr = set_full[SET_W-1:0];
        st_re       = accept;
        st_rd_addr  = set_full[SET_W-1:0];
        tag_we      = miss_wb;
        tag_wr_addr = set_reg;
        tag_wr_data = tag_row_new;
        st_we       = miss_wb || (state_reg == ST_CLEAR);
        st_wr_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
        st_wr_data  = (state_reg == ST_CLEAR) ? '0 : {valid_new, ptr_new};
        res.fire    = (state_reg == ST_LOOKUP);
        res.hit     = hit_any;
        res.way     = hit_any ? 2'(hit_way) : 2'(v_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        tag_reg <= tag_next;
    end

    `SACTR_ASSERT_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP, "beat not looked up")
    `SACTR_ASSERT_NEXT(a_single_lookup, state_reg == ST_LOOKUP, state_reg == ST_IDLE, "stuck")
    `SACTR_ASSERT_NOW(a_no_read_on_write, tag_we || st_we, !tag_re && !st_re, "read during write")
    `SACTR_ASSERT_NOW(a_victim_in_range, res.fire && !res.hit, CW'(v_sel) < CW'(nw_eff), "bad way")

endmodule

>>> sv/set_assoc_cache_tag_round_robin_top.sv
`timescale 1ns / 1ps
// Channel   Beat marked by     Payload
// command   start && !busy     address
// result    done               hit, way, request_count, miss_count
// config    cfg_we             cfg_index, cfg_data
//
// Each lookup reads the set row from the tag and state memories (registered
// read), then compares it and writes it back on a miss.
// done pulses for one cycle, registered from the lookup state that follows the accepted start.
// After reset a sweep clears every set of the state memory with busy high;
// config writes are taken during it. The result side cannot stall.

module set_assoc_cache_tag_round_robin_top #(
    parameter int SETS = 256,
    parameter int WAYS = 4,
    parameter int ADDR_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sactr_pkg::ADR_W-1:0]       address,
    output logic                              done,
    output logic                              hit,
    output logic [1:0]                        way,
    output logic [sactr_pkg::CNT_W-1:0]       request_count,
    output logic [sactr_pkg::CNT_W-1:0]       miss_count,
    input  logic                              cfg_we,
    input  logic [sactr_pkg::IDX_W-1:0]       cfg_index,
    input  logic [sactr_pkg::CFG_W-1:0]       cfg_data
);

    import sactr_pkg::*;

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W = (ADDR_BITS < 32) ? ADDR_BITS : 32;

    cfg_t             cfg_reg, cfg_next;
    res_t             res;
    logic [CNT_W-1:0] req_reg, req_next;
    logic [CNT_W-1:0] miss_reg, miss_next;
    logic             done_reg;
    logic             hit_reg;
    logic [1:0]       way_reg;

    logic                       tag_re, tag_we;
    logic [SET_W-1:0]           tag_rd_addr, tag_wr_addr;
    logic [WAYS-1:0][TAG_W-1:0] tag_rd_data, tag_wr_data;
    logic                       st_re, st_we;
    logic [SET_W-1:0]           st_rd_addr, st_wr_addr;
    logic [WAYS+WAY_W-1:0]      st_rd_data, st_wr_data;

    sactr_ram #(
        .DEPTH (SETS),
        .WIDTH (WAYS * TAG_W)
    ) u_tag_ram (
        .clk     (clk),
        .we      (tag_we),
        .wr_addr (tag_wr_addr),
        .wr_data (tag_wr_data),
        .re      (tag_re),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    sactr_ram #(
        .DEPTH (SETS),
        .WIDTH (WAYS + WAY_W)
    ) u_state_ram (
        .clk     (clk),
        .we      (st_we),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .re      (st_re),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    sactr_ctrl #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .address     (address),
        .cfg         (cfg_reg),
        .busy        (busy),
        .res         (res),
        .tag_re      (tag_re),
        .tag_rd_addr (tag_rd_addr),
        .tag_rd_data (tag_rd_data),
        .tag_we      (tag_we),
        .tag_wr_addr (tag_wr_addr),
        .tag_wr_data (tag_wr_data),
        .st_re       (st_re),
        .st_rd_addr  (st_rd_addr),
        .st_rd_data  (st_rd_data),
        .st_we       (st_we),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLOCK_SHIFT: cfg_next.block_shift = cfg_data;
                REG_SET_BITS:    cfg_next.set_bits    = cfg_data;
                REG_WAYS_IN_USE: cfg_next.ways_in_use = cfg_data[2:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // saturating counters: requests bumped once per result beat, misses only on a miss beat
    always_comb
    begin
        req_next  = req_reg;
        miss_next = miss_reg;
        if (res.fire)
        begin
            req_next = (req_reg == '1) ? req_reg : req_reg + CNT_W'(1);
            if (!res.hit)
            begin
                miss_next = (miss_reg == '1) ? miss_reg : miss_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_shift <= 4'd2;
            cfg_reg.set_bits    <= 4'd8;
            cfg_reg.ways_in_use <= 3'd4;
            req_reg             <= '0;
            miss_reg            <= '0;
            done_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            req_reg  <= req_next;
            miss_reg <= miss_next;
            done_reg <= res.fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.fire)
        begin
            hit_reg <= res.hit;
            way_reg <= res.way;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign way           = way_reg;
    assign request_count = req_reg;
    assign miss_count    = miss_reg;

endmodule
